FILE: hw/rtl/fed_pkg.sv
// Shared types and constants for the flight event detector.
package fed_pkg;

  typedef enum logic [2:0] {
    PH_PAD    = 3'd0,
    PH_ASCENT = 3'd1,
    PH_DROGUE = 3'd2,
    PH_MAIN   = 3'd3,
    PH_LANDED = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam logic [2:0] REG_RUN_MODE    = 3'd0;
  localparam logic [2:0] REG_MAIN_HIGH   = 3'd1;
  localparam logic [2:0] REG_MAIN_LOW    = 3'd2;
  localparam logic [2:0] REG_RISE_FLIGHT = 3'd3;
  localparam logic [2:0] REG_RISE_TEST   = 3'd4;
  localparam logic [2:0] REG_HIGH_MARK   = 3'd5;
  localparam logic [2:0] REG_RATE_UPPER  = 3'd6;
  localparam logic [2:0] REG_RATE_LOWER  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Run modes
  localparam logic MODE_FLIGHT = 1'b0;
  localparam logic MODE_TEST   = 1'b1;

  // Test flag bit positions
  localparam int FLG_LAUNCH    = 0;
  localparam int FLG_MOTOR_OUT = 1;
  localparam int FLG_HIGH_ALT  = 2;
  localparam int FLG_TILT      = 3;
  localparam int FLG_DESCENT   = 4;
  localparam int FLG_DROGUE    = 5;
  localparam int FLG_BELOW_TOP = 6;
  localparam int FLG_MAIN      = 7;

  // Altitude drop that apogee detection must exceed, dm
  localparam logic signed [19:0] DESCENT_MIN_DM = 20'sd10;

  // Reset values of the configuration registers
  localparam logic               RST_RUN_MODE    = 1'b0;
  localparam logic [17:0]        RST_MAIN_HIGH   = 18'd6000;
  localparam logic [17:0]        RST_MAIN_LOW    = 18'd4000;
  localparam logic [13:0]        RST_RISE_FLIGHT = 14'd100;
  localparam logic [13:0]        RST_RISE_TEST   = 14'd50;
  localparam logic [17:0]        RST_HIGH_MARK   = 18'd20000;
  localparam logic signed [15:0] RST_RATE_UPPER  = 16'sd500;
  localparam logic signed [15:0] RST_RATE_LOWER  = -16'sd600;

  typedef struct packed {
    logic signed [18:0] altitude_dm;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] pitch_rate;
  } in_t;

  typedef struct packed {
    logic [2:0] flight_phase;
    logic [7:0] test_flags;
    logic       drogue_fire;
    logic       main_fire;
  } out_t;

  typedef struct packed {
    logic               run_mode;
    logic [17:0]        main_window_high;
    logic [17:0]        main_window_low;
    logic [13:0]        launch_rise_flight;
    logic [13:0]        launch_rise_test;
    logic [17:0]        high_altitude_mark;
    logic signed [15:0] rate_upper_limit;
    logic signed [15:0] rate_lower_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [18:0] baseline_alt;
    logic               baseline_valid;
    logic signed [18:0] previous_alt;
    phase_t             phase;
    logic [7:0]         flags;
    logic               drogue_latch;
    logic               main_latch;
  } state_t;

endpackage

FILE: hw/rtl/fed_cfg_regs.sv
// Configuration register file of the flight event detector.
module fed_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output fed_pkg::cfg_t                   cfg
);
  import fed_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_RUN_MODE:    cfg_nxt.run_mode           = cfg_wdata[0];
        REG_MAIN_HIGH:   cfg_nxt.main_window_high   = cfg_wdata[17:0];
        REG_MAIN_LOW:    cfg_nxt.main_window_low    = cfg_wdata[17:0];
        REG_RISE_FLIGHT: cfg_nxt.launch_rise_flight = cfg_wdata[13:0];
        REG_RISE_TEST:   cfg_nxt.launch_rise_test   = cfg_wdata[13:0];
        REG_HIGH_MARK:   cfg_nxt.high_altitude_mark = cfg_wdata[17:0];
        REG_RATE_UPPER:  cfg_nxt.rate_upper_limit   = $signed(cfg_wdata[15:0]);
        REG_RATE_LOWER:  cfg_nxt.rate_lower_limit   = $signed(cfg_wdata[15:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_mode           <= RST_RUN_MODE;
      cfg_r.main_window_high   <= RST_MAIN_HIGH;
      cfg_r.main_window_low    <= RST_MAIN_LOW;
      cfg_r.launch_rise_flight <= RST_RISE_FLIGHT;
      cfg_r.launch_rise_test   <= RST_RISE_TEST;
      cfg_r.high_altitude_mark <= RST_HIGH_MARK;
      cfg_r.rate_upper_limit   <= RST_RATE_UPPER;
      cfg_r.rate_lower_limit   <= RST_RATE_LOWER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/fed_step.sv
// Per-sample next-state logic: pitch test, flight phase and test flag sequencing.
module fed_step (
  input  fed_pkg::cfg_t   cfg,
  input  fed_pkg::state_t st,
  input  fed_pkg::in_t    item,
  output fed_pkg::state_t st_nxt
);
  import fed_pkg::*;

  logic signed [18:0] base;
  logic signed [19:0] alt_w;
  logic signed [19:0] prev_w;
  logic signed [19:0] rise;
  logic signed [19:0] drop;
  logic signed [19:0] hi_w;
  logic signed [19:0] lo_w;
  logic signed [19:0] rise_flt_w;
  logic signed [19:0] rise_tst_w;
  logic signed [19:0] mark_w;
  logic               in_window;
  logic               below_hi;
  logic signed [31:0] ax2;
  logic signed [31:0] ay2;
  logic signed [31:0] az2;
  logic [31:0]        r2;
  logic [33:0]        r2x3;
  logic               steep;
  phase_t             ph;
  logic [7:0]         fl;
  logic               dr;
  logic               mn;

  // First sample loads the baseline before any test
  assign base       = st.baseline_valid ? st.baseline_alt : item.altitude_dm;
  assign alt_w      = {item.altitude_dm[18], item.altitude_dm};
  assign prev_w     = {st.previous_alt[18], st.previous_alt};
  assign rise       = alt_w - {base[18], base};
  assign drop       = prev_w - alt_w;
  assign hi_w       = {2'b00, cfg.main_window_high};
  assign lo_w       = {2'b00, cfg.main_window_low};
  assign rise_flt_w = {6'd0, cfg.launch_rise_flight};
  assign rise_tst_w = {6'd0, cfg.launch_rise_test};
  assign mark_w     = {2'b00, cfg.high_altitude_mark};
  assign below_hi   = alt_w < hi_w;
  assign in_window  = below_hi && (alt_w > lo_w);

  // |pitch| > 60 deg  <=>  ax^2 > 3 (ay^2 + az^2); squares are non-negative
  assign ax2   = item.accel_x * item.accel_x;
  assign ay2   = item.accel_y * item.accel_y;
  assign az2   = item.accel_z * item.accel_z;
  assign r2    = {1'b0, ay2[30:0]} + {1'b0, az2[30:0]};
  assign r2x3  = {1'b0, r2, 1'b0} + {2'b00, r2};
  assign steep = {3'b000, ax2[30:0]} > r2x3;

  always_comb begin
    ph = st.phase;
    fl = st.flags;
    dr = st.drogue_latch;
    mn = st.main_latch;
    if (cfg.run_mode == MODE_FLIGHT) begin
      // Rules cascade within one sample
      if (ph == PH_PAD && rise > rise_flt_w) ph = PH_ASCENT;
      if (ph == PH_ASCENT && drop > DESCENT_MIN_DM && steep) begin
        ph = PH_DROGUE;
        dr = 1'b1;
      end
      if (ph == PH_DROGUE && in_window) begin
        ph = PH_MAIN;
        mn = 1'b1;
      end
      if (ph == PH_MAIN && alt_w == prev_w) ph = PH_LANDED;
    end else begin
      if (rise > rise_tst_w) fl[FLG_LAUNCH] = 1'b1;
      if (fl[FLG_LAUNCH] && item.accel_z[15]) fl[FLG_MOTOR_OUT] = 1'b1;
      if (alt_w > mark_w) fl[FLG_HIGH_ALT] = 1'b1;
      if (item.pitch_rate > cfg.rate_upper_limit ||
          item.pitch_rate < cfg.rate_lower_limit) fl[FLG_TILT] = 1'b1;
      if (drop > 20'sd0 && fl[FLG_TILT]) fl[FLG_DESCENT] = 1'b1;
      if (fl[FLG_MOTOR_OUT] && fl[FLG_DESCENT] && fl[FLG_TILT]) begin
        fl[FLG_DROGUE] = 1'b1;
        dr = 1'b1;
      end
      if (below_hi && fl[FLG_DROGUE]) fl[FLG_BELOW_TOP] = 1'b1;
      if (fl[FLG_BELOW_TOP] && in_window) begin
        fl[FLG_MAIN] = 1'b1;
        mn = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt.baseline_alt   = base;
    st_nxt.baseline_valid = 1'b1;
    st_nxt.previous_alt   = item.altitude_dm;
    st_nxt.phase          = ph;
    st_nxt.flags          = fl;
    st_nxt.drogue_latch   = dr;
    st_nxt.main_latch     = mn;
  end

endmodule

FILE: hw/rtl/flight_event_detector.sv
// Top level of the flight event detector: sample register, state and result register.
//
//  channel | ports                             | payload
//  --------+-----------------------------------+------------------------------
//  input   | in_valid / in_ready / in_data     | fed_pkg::in_t  (one sample)
//  result  | out_valid / out_ready / out_data  | fed_pkg::out_t (state after it)
//  config  | cfg_we / cfg_idx / cfg_wdata      | register write, no read-back
//
// One sample per cycle sustained while out_ready stays high; an accepted sample enters the
// sample register, then moves into the result register, where out_valid rises.
// The sample register feeds one pass of compare/square logic into the result register,
// and the detector state is updated at the same edge as the result register.
// Synchronous active-low reset clears state and loads the register defaults.
// A stalled result holds in the output register; one more sample can wait in the
// sample register, then in_ready drops until out_ready frees the result register.
module flight_event_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fed_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fed_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fed_pkg::*;

  cfg_t   cfg;
  in_t    smp_r;
  in_t    smp_nxt;
  logic   smp_valid_r;
  logic   smp_valid_nxt;
  state_t st_r;
  state_t st_nxt;
  state_t st_step;
  out_t   res_r;
  out_t   res_nxt;
  logic   res_valid_r;
  logic   res_valid_nxt;
  logic   advance;
  logic   in_fire;

  fed_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fed_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (smp_r),
    .st_nxt (st_step)
  );

  assign advance  = smp_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !smp_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    smp_nxt       = in_fire ? in_data : smp_r;
    smp_valid_nxt = in_fire || (smp_valid_r && !advance);
    st_nxt        = advance ? st_step : st_r;
    res_valid_nxt = advance || (res_valid_r && !out_ready);
    res_nxt       = res_r;
    if (advance) begin
      res_nxt.flight_phase = st_step.phase;
      res_nxt.test_flags   = st_step.flags;
      res_nxt.drogue_fire  = st_step.drogue_latch;
      res_nxt.main_fire    = st_step.main_latch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      st_r        <= '{baseline_alt: '0, baseline_valid: 1'b0, previous_alt: '0,
                       phase: PH_PAD, flags: '0, drogue_latch: 1'b0,
                       main_latch: 1'b0};
    end else begin
      smp_valid_r <= smp_valid_nxt;
      res_valid_r <= res_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

FILE: hw/rtl/fed_checker.sv
// Port-level checks for the flight event detector, bound to the top level.
module fed_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input fed_pkg::out_t out_data
);
  import fed_pkg::*;

  logic       drogue_seen_r;
  logic       main_seen_r;
  logic [7:0] flags_seen_r;
  logic [2:0] phase_seen_r;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // Track what earlier transactions showed; latches, flags and phase only move forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drogue_seen_r <= 1'b0;
      main_seen_r   <= 1'b0;
      flags_seen_r  <= '0;
      phase_seen_r  <= '0;
    end else if (out_fire) begin
      drogue_seen_r <= drogue_seen_r | out_data.drogue_fire;
      main_seen_r   <= main_seen_r | out_data.main_fire;
      flags_seen_r  <= flags_seen_r | out_data.test_flags;
      phase_seen_r  <= out_data.flight_phase;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_drogue_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drogue_seen_r |-> out_data.drogue_fire)
    else $error("drogue fire dropped");

  a_main_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && main_seen_r |-> out_data.main_fire)
    else $error("main fire dropped");

  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.test_flags & flags_seen_r) == flags_seen_r)
    else $error("test flag cleared");

  a_phase_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.flight_phase >= phase_seen_r)
    else $error("flight phase went backward");

endmodule

bind flight_event_detector fed_checker u_fed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the flight event detector: random samples, live prediction.
module tb_top;
  import fed_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Mirrors the detector state and registers, predicts the report for each sample
  class event_scoreboard;
    cfg_t   regs;
    state_t st;
    out_t   expected_reports[$];
    int     errors;
    int     checked;

    function new();
      regs.run_mode           = RST_RUN_MODE;
      regs.main_window_high   = RST_MAIN_HIGH;
      regs.main_window_low    = RST_MAIN_LOW;
      regs.launch_rise_flight = RST_RISE_FLIGHT;
      regs.launch_rise_test   = RST_RISE_TEST;
      regs.high_altitude_mark = RST_HIGH_MARK;
      regs.rate_upper_limit   = RST_RATE_UPPER;
      regs.rate_lower_limit   = RST_RATE_LOWER;
      st      = '0;
      st.phase = PH_PAD;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [17:0] val);
      case (idx)
        REG_RUN_MODE:    regs.run_mode           = val[0];
        REG_MAIN_HIGH:   regs.main_window_high   = val;
        REG_MAIN_LOW:    regs.main_window_low    = val;
        REG_RISE_FLIGHT: regs.launch_rise_flight = val[13:0];
        REG_RISE_TEST:   regs.launch_rise_test   = val[13:0];
        REG_HIGH_MARK:   regs.high_altitude_mark = val;
        REG_RATE_UPPER:  regs.rate_upper_limit   = val[15:0];
        REG_RATE_LOWER:  regs.rate_lower_limit   = val[15:0];
        default: ;
      endcase
    endfunction

    // |pitch| > 60 deg  <=>  ax^2 > 3 (ay^2 + az^2)
    function bit steep_attitude(in_t s);
      longint ax, ay, az;
      ax = longint'($signed(s.accel_x));
      ay = longint'($signed(s.accel_y));
      az = longint'($signed(s.accel_z));
      return (ax * ax) > 3 * (ay * ay + az * az);
    endfunction

    function void predict_sample(in_t s);
      longint alt, rise, drop, hi, lo, rate;
      logic [7:0] f;
      out_t r;
      alt  = longint'($signed(s.altitude_dm));
      rate = longint'($signed(s.pitch_rate));
      hi   = longint'(regs.main_window_high);
      lo   = longint'(regs.main_window_low);
      if (!st.baseline_valid) begin
        st.baseline_alt   = s.altitude_dm;
        st.baseline_valid = 1'b1;
      end
      rise = alt - longint'($signed(st.baseline_alt));
      drop = longint'($signed(st.previous_alt)) - alt;

      if (regs.run_mode == MODE_FLIGHT) begin
        // transitions cascade within one sample
        if (st.phase == PH_PAD && rise > longint'(regs.launch_rise_flight))
          st.phase = PH_ASCENT;
        if (st.phase == PH_ASCENT && drop > longint'(DESCENT_MIN_DM) && steep_attitude(s)) begin
          st.phase        = PH_DROGUE;
          st.drogue_latch = 1'b1;
        end
        if (st.phase == PH_DROGUE && alt < hi && alt > lo) begin
          st.phase      = PH_MAIN;
          st.main_latch = 1'b1;
        end
        if (st.phase == PH_MAIN && s.altitude_dm == st.previous_alt)
          st.phase = PH_LANDED;
      end else begin
        f = st.flags;
        if (rise > longint'(regs.launch_rise_test)) f[FLG_LAUNCH] = 1'b1;
        if (f[FLG_LAUNCH] && s.accel_z[15]) f[FLG_MOTOR_OUT] = 1'b1;
        if (alt > longint'(regs.high_altitude_mark)) f[FLG_HIGH_ALT] = 1'b1;
        if (rate > longint'(regs.rate_upper_limit) || rate < longint'(regs.rate_lower_limit))
          f[FLG_TILT] = 1'b1;
        if (drop > 0 && f[FLG_TILT]) f[FLG_DESCENT] = 1'b1;
        if (f[FLG_MOTOR_OUT] && f[FLG_DESCENT] && f[FLG_TILT]) begin
          f[FLG_DROGUE]   = 1'b1;
          st.drogue_latch = 1'b1;
        end
        if (alt < hi && f[FLG_DROGUE]) f[FLG_BELOW_TOP] = 1'b1;
        if (f[FLG_BELOW_TOP] && alt < hi && alt > lo) begin
          f[FLG_MAIN]   = 1'b1;
          st.main_latch = 1'b1;
        end
        st.flags = f;
      end
      st.previous_alt = s.altitude_dm;

      r.flight_phase = st.phase;
      r.test_flags   = st.flags;
      r.drogue_fire  = st.drogue_latch;
      r.main_fire    = st.main_latch;
      expected_reports.push_back(r);
    endfunction

    task report(string what, int exp_v, int got_v);
      $display("mismatch at report %0d: %s expected %0h got %0h", checked, what, exp_v, got_v);
      errors++;
    endtask

    task check_report(out_t got);
      out_t want;
      if (expected_reports.size() == 0) begin
        report("unexpected transaction", 0, int'(got));
        return;
      end
      want = expected_reports.pop_front();
      if (got.flight_phase !== want.flight_phase)
        report("flight_phase", want.flight_phase, got.flight_phase);
      if (got.test_flags !== want.test_flags)
        report("test_flags", want.test_flags, got.test_flags);
      if (got.drogue_fire !== want.drogue_fire)
        report("drogue_fire", want.drogue_fire, got.drogue_fire);
      if (got.main_fire !== want.main_fire)
        report("main_fire", want.main_fire, got.main_fire);
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  event_scoreboard sb;
  int in_idle_pct;
  int out_stall_pct;
  int hold_left;
  int cycle_count;
  int cfg_writes;

  flight_event_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_report(out_data);
  end

  function automatic int srand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int r16();
    return srand(-32768, 32767);
  endfunction

  function automatic in_t mk_sample(int alt, int ax, int ay, int az, int rate);
    in_t s;
    s.altitude_dm = alt[18:0];
    s.accel_x     = ax[15:0];
    s.accel_y     = ay[15:0];
    s.accel_z     = az[15:0];
    s.pitch_rate  = rate[15:0];
    return s;
  endfunction

  function automatic in_t noise_sample(int alt_lo, int alt_hi);
    return mk_sample(srand(alt_lo, alt_hi), r16(), r16(), r16(), r16());
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic offer_sample(in_t s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = s;
    do @(posedge clk); while (!in_ready);
    sb.predict_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_for_reports();
    in_valid = 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // block must be idle
  task automatic write_cfg(logic [2:0] idx, logic [17:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_idling(int in_pct, int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  // pad, launch, climb, shallow coast, apogee, drogue descent, main window, touchdown, then noise
  task automatic fly_flight_profile(int total);
    int cur, apex, mag, n;
    n   = 0;
    cur = 1000;
    repeat (5) begin
      offer_sample(mk_sample(cur + srand(-200, 100), r16(), r16(), r16(), r16()));
      n++;
    end
    apex = srand(25000, 60000);
    while (cur < apex) begin
      cur += srand(-10, 900);
      offer_sample(mk_sample(cur, r16(), r16(), r16(), r16()));
      n++;
    end
    // steep but only a 10 dm drop: no apogee yet
    cur -= 10;
    offer_sample(mk_sample(cur, 30000, 0, 0, r16()));
    n++;
    repeat (srand(3, 8)) begin
      cur -= srand(11, 150);
      mag = srand(8000, 32767);
      offer_sample(mk_sample(cur, srand(-1000, 1000), ($urandom_range(1) ? mag : -mag),
                             r16(), r16()));
      n++;
    end
    cur -= srand(11, 300);
    mag = srand(20000, 32767);
    offer_sample(mk_sample(cur, ($urandom_range(1) ? mag : -mag), srand(-5000, 5000),
                           srand(-5000, 5000), r16()));
    n++;
    while (cur > 1500) begin
      cur -= srand(50, 900);
      offer_sample(mk_sample(cur, r16(), r16(), r16(), r16()));
      n++;
    end
    repeat (srand(3, 6)) begin
      offer_sample(mk_sample(cur, r16(), r16(), r16(), r16()));
      n++;
    end
    while (n < total) begin
      offer_sample(noise_sample(-20000, 200000));
      n++;
    end
  endtask

  // ground test run: climb above the high mark, tilt, descend into the main window
  task automatic run_test_sequence();
    int cur, top;
    cur = 1000;
    top = srand(22000, 30000);
    while (cur < top) begin
      cur += srand(-100, 600);
      offer_sample(mk_sample(cur, r16(), r16(), r16(), srand(-1500, 1500)));
    end
    while (cur > 2000) begin
      cur += srand(-700, 80);
      offer_sample(mk_sample(cur, r16(), r16(), r16(), srand(-1500, 1500)));
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    hold_left   = 0;
    cycle_count = 0;
    cfg_writes  = 0;
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, flight mode on pad; first sample sets the baseline
    offer_sample(mk_sample(1000, 0, 0, 0, 0));
    offer_sample(mk_sample(1100, 32767, -32768, 0, 32767));   // rise equals threshold
    offer_sample(mk_sample(-262144, -32768, 0, 0, -32768));
    offer_sample(mk_sample(1100, -32768, -32768, -32768, -20000));
    offer_sample(mk_sample(1101 - 101, 21845, 10922, -1, 20000));
    offer_sample(mk_sample(-20000, -21846, -10923, 32767, 500));
    offer_sample(mk_sample(0, 0, 32767, -32768, -600));
    offer_sample(mk_sample(-1, 1, 1, 1, -1));
    offer_sample(mk_sample(1100, 0, 0, 0, 0));
    wait_for_reports();

    // pad noise with the largest launch threshold
    write_cfg(REG_RISE_FLIGHT, 18'h03FFF);
    write_cfg(REG_MAIN_HIGH, 18'h3FFFF);
    write_cfg(REG_MAIN_LOW, 18'h3FFFF);
    set_idling(85, 0);
    repeat (150) offer_sample(noise_sample(-262144, 1000 + 16383));
    wait_for_reports();

    // ground test mode, limits at extremes so few flags can set
    write_cfg(REG_RUN_MODE, {17'($urandom), MODE_TEST});
    write_cfg(REG_RISE_TEST, 18'h03FFF);
    write_cfg(REG_HIGH_MARK, 18'h3FFFF);
    write_cfg(REG_RATE_UPPER, {2'($urandom), 16'sh7FFF});
    write_cfg(REG_RATE_LOWER, {2'($urandom), 16'sh8000});
    write_cfg(REG_MAIN_HIGH, 18'h00000);
    write_cfg(REG_MAIN_LOW, 18'h00000);
    set_idling(0, 85);
    repeat (150) begin
      if ($urandom_range(9) == 0)
        offer_sample(noise_sample(-262144, 262143));
      else
        offer_sample(noise_sample(-262144, 1000 + 16383));
    end
    wait_for_reports();

    // full flight with a long output hold-off at the start
    write_cfg(REG_RUN_MODE, 18'(MODE_FLIGHT));
    write_cfg(REG_RISE_FLIGHT, 18'd100);
    write_cfg(REG_MAIN_HIGH, 18'd6000);
    write_cfg(REG_MAIN_LOW, 18'd4000);
    set_idling(34, 34);
    hold_left = 120;
    fly_flight_profile(280);
    wait_for_reports();

    write_cfg(REG_RUN_MODE, 18'(MODE_TEST));
    write_cfg(REG_RISE_TEST, 18'd50);
    write_cfg(REG_HIGH_MARK, 18'd20000);
    write_cfg(REG_RATE_UPPER, 18'(16'sd500));
    write_cfg(REG_RATE_LOWER, 18'(-16'sd600) & 18'h0FFFF);
    set_idling(85, 0);
    run_test_sequence();
    wait_for_reports();

    // noise over the whole field range, most registers at their other extremes
    write_cfg(REG_MAIN_HIGH, 18'h3FFFF);
    write_cfg(REG_MAIN_LOW, 18'h00000);
    write_cfg(REG_HIGH_MARK, 18'h00000);
    write_cfg(REG_RISE_TEST, 18'h00000);
    write_cfg(REG_RISE_FLIGHT, 18'h00000);
    write_cfg(REG_RATE_UPPER, 18'(16'sd20000));
    write_cfg(REG_RATE_LOWER, 18'(-16'sd20000) & 18'h0FFFF);
    set_idling(0, 85);
    repeat (130) offer_sample(noise_sample(-262144, 262143));
    wait_for_reports();
    repeat (8) @(posedge clk);

    $display("summary: %0d reports checked in flight and ground test modes, %0d register writes",
             sb.checked, cfg_writes);
    $display("summary: final phase %0d, flags %08b, drogue %0b, main %0b",
             sb.st.phase, sb.st.flags, sb.st.drogue_latch, sb.st.main_latch);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
